[src/tdr_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the trapezoidal duty ramp unit.
package tdr_pkg;

    // Field widths.
    localparam int unsigned PULSE_W = 32;
    localparam int unsigned DUTY_W  = 7;
    localparam int unsigned STEP_W  = 7;
    localparam int unsigned IVL_W   = 10;
    localparam int unsigned HOLD_W  = 16;
    localparam int unsigned CIDX_W  = 3;
    localparam int unsigned CDATA_W = 16;

    // Ramp phases as reported on the phase field.
    typedef enum logic [1:0] {
        PH_ACCEL  = 2'd0,
        PH_HOLD   = 2'd1,
        PH_MIRROR = 2'd2,
        PH_DECEL  = 2'd3
    } t_phase;

    // Configuration register indexes.
    typedef enum logic [CIDX_W-1:0] {
        REG_DUTY_MIN   = 3'd0,
        REG_DUTY_MAX   = 3'd1,
        REG_STEP_UP    = 3'd2,
        REG_STEP_DOWN  = 3'd3,
        REG_STEP_IVL   = 3'd4,
        REG_HOLD_LIMIT = 3'd5
    } t_reg_idx;

    // Reset values of the configuration registers.
    localparam logic [DUTY_W-1:0] DUTY_MIN_RST   = 7'd30;
    localparam logic [DUTY_W-1:0] DUTY_MAX_RST   = 7'd70;
    localparam logic [STEP_W-1:0] STEP_UP_RST    = 7'd1;
    localparam logic [STEP_W-1:0] STEP_DOWN_RST  = 7'd1;
    localparam logic [IVL_W-1:0]  STEP_IVL_RST   = 10'd50;
    localparam logic [HOLD_W-1:0] HOLD_LIMIT_RST = 16'd30000;

    // Configuration register set.
    typedef struct packed {
        logic [DUTY_W-1:0] duty_min;
        logic [DUTY_W-1:0] duty_max;
        logic [STEP_W-1:0] step_up;
        logic [STEP_W-1:0] step_down;
        logic [IVL_W-1:0]  step_ivl;
        logic [HOLD_W-1:0] hold_limit;
    } t_cfg;

    // Result of one tick as handed from the ramp core to the result register.
    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        t_phase            phase;
    } t_result;

endpackage

[src/tdr_if.sv]
`timescale 1ns / 1ps
// Handshake channel interfaces of the trapezoidal duty ramp unit.
interface tdr_in_if;
    logic                         valid;
    logic                         ready;
    logic [tdr_pkg::PULSE_W-1:0]  pulses_now;
    logic [tdr_pkg::PULSE_W-1:0]  pulses_target;

    modport source (output valid, pulses_now, pulses_target, input ready);
    modport sink   (input valid, pulses_now, pulses_target, output ready);
endinterface

interface tdr_out_if;
    logic                        valid;
    logic                        ready;
    logic [tdr_pkg::DUTY_W-1:0]  duty;
    logic [1:0]                  phase;

    modport source (output valid, duty, phase, input ready);
    modport sink   (input valid, duty, phase, output ready);
endinterface

interface tdr_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [tdr_pkg::CIDX_W-1:0]   index;
    logic [tdr_pkg::CDATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[src/trapezoidal_duty_ramp_unit.sv]
`timescale 1ns / 1ps
// Top level of the trapezoidal duty ramp unit.
//
// Each input beat is one millisecond tick with the pulses travelled and the pulses the move
// needs; each tick yields exactly one output beat with the duty percent and ramp phase after
// that tick. A tick passes through an input register and a result register. The result
// register loads from the input register when it is empty or its beat is being taken, so
// one tick can be accepted every cycle while the output is not stalled; the combinational
// phase and duty update on the ramp state sets that rate. Output back-pressure stalls both
// stages; while a finished result waits, one more beat is still taken into the input
// register if it is empty. Configuration writes are always ready and should be issued only
// while no tick is in flight.
module trapezoidal_duty_ramp_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tdr_in_if.sink    i_in,
    tdr_cfg_if.sink   i_cfg,
    tdr_out_if.source o_out
);
    import tdr_pkg::*;

    t_cfg    r_cfg;
    logic    r_s1_vld;
    logic    r_s1_below_half;
    logic    r_out_vld;
    t_result r_out;
    t_result core_next;

    logic out_free;
    logic advance;
    logic in_fire;
    logic cfg_fire;

    // Stage handshakes: the result register frees up when it is empty or being taken.
    assign out_free  = !r_out_vld || o_out.ready;
    assign advance   = r_s1_vld && out_free;
    assign i_in.ready = !r_s1_vld || advance;
    assign in_fire   = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign cfg_fire  = i_cfg.valid;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.duty_min   <= DUTY_MIN_RST;
            r_cfg.duty_max   <= DUTY_MAX_RST;
            r_cfg.step_up    <= STEP_UP_RST;
            r_cfg.step_down  <= STEP_DOWN_RST;
            r_cfg.step_ivl   <= STEP_IVL_RST;
            r_cfg.hold_limit <= HOLD_LIMIT_RST;
        end else if (cfg_fire) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_DUTY_MIN:   r_cfg.duty_min   <= i_cfg.data[DUTY_W-1:0];
                REG_DUTY_MAX:   r_cfg.duty_max   <= i_cfg.data[DUTY_W-1:0];
                REG_STEP_UP:    r_cfg.step_up    <= i_cfg.data[STEP_W-1:0];
                REG_STEP_DOWN:  r_cfg.step_down  <= i_cfg.data[STEP_W-1:0];
                REG_STEP_IVL:   r_cfg.step_ivl   <= i_cfg.data[IVL_W-1:0];
                REG_HOLD_LIMIT: r_cfg.hold_limit <= i_cfg.data[HOLD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register: only the halfway comparison is kept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_below_half <= (i_in.pulses_now < (i_in.pulses_target >> 1));
        end
    end

    tdr_ramp_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (advance),
        .i_below_half (r_s1_below_half),
        .i_cfg        (r_cfg),
        .o_next       (core_next)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_next;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.duty  = r_out.duty;
    assign o_out.phase = r_out.phase;

    // A result only appears after a tick sat in the input register.
    a_out_from_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_s1_vld))
        else $error("result beat without a registered tick");

    // A result beat that is not taken stays offered.
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> o_out.valid)
        else $error("result beat withdrawn before it was taken");

    // The payload of a waiting result beat does not change.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> $stable(r_out))
        else $error("result payload changed while waiting");

endmodule

[src/tdr_ramp_core.sv]
`timescale 1ns / 1ps
// Ramp state registers and the per-tick phase and duty update.
module tdr_ramp_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_below_half,
    input  tdr_pkg::t_cfg    i_cfg,
    output tdr_pkg::t_result o_next
);
    import tdr_pkg::*;

    t_phase            r_phase, n_phase;
    logic [DUTY_W-1:0] r_duty, n_duty;
    logic [IVL_W-1:0]  r_step_timer, n_step_timer;
    logic [HOLD_W-1:0] r_hold_timer, n_hold_timer;

    logic [IVL_W-1:0]  timer_dec;
    logic              timer_zero;
    logic [DUTY_W:0]   duty_up_sum;
    logic [DUTY_W-1:0] duty_above_min;

    // The step timer counts down before the phase logic looks at it.
    assign timer_dec      = (r_step_timer != '0) ? r_step_timer - 1'b1 : '0;
    assign timer_zero     = (timer_dec == '0);
    assign duty_up_sum    = {1'b0, r_duty} + {1'b0, i_cfg.step_up};
    assign duty_above_min = r_duty - i_cfg.duty_min;

    // Next state of the ramp for one tick.
    always_comb begin
        n_phase      = r_phase;
        n_duty       = r_duty;
        n_step_timer = timer_dec;
        n_hold_timer = r_hold_timer;
        if (i_below_half) begin
            unique case (r_phase)
                PH_ACCEL: begin
                    if (r_duty < i_cfg.duty_max) begin
                        if (timer_zero) begin
                            n_step_timer = i_cfg.step_ivl;
                            n_duty = (duty_up_sum > {1'b0, i_cfg.duty_max})
                                   ? i_cfg.duty_max : duty_up_sum[DUTY_W-1:0];
                        end
                    end else begin
                        n_phase      = PH_HOLD;
                        n_hold_timer = '0;
                    end
                end
                PH_HOLD: begin
                    if (r_hold_timer < i_cfg.hold_limit) begin
                        n_hold_timer = r_hold_timer + 1'b1;
                    end
                end
                PH_MIRROR, PH_DECEL: begin
                    n_phase = PH_ACCEL;
                end
                default: begin
                    n_phase = PH_ACCEL;
                end
            endcase
        end else begin
            unique case (r_phase)
                PH_ACCEL: begin
                    n_phase = PH_DECEL;
                end
                PH_HOLD: begin
                    n_phase = PH_MIRROR;
                end
                PH_MIRROR: begin
                    if (r_hold_timer == '0) begin
                        n_phase = PH_DECEL;
                    end else begin
                        n_hold_timer = r_hold_timer - 1'b1;
                    end
                end
                PH_DECEL: begin
                    if (r_duty > i_cfg.duty_min && timer_zero) begin
                        n_step_timer = i_cfg.step_ivl;
                        n_duty = (duty_above_min <= i_cfg.step_down)
                               ? i_cfg.duty_min : r_duty - i_cfg.step_down;
                    end
                end
                default: begin
                    n_phase = PH_DECEL;
                end
            endcase
        end
    end

    // State advances once per tick that moves into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_ACCEL;
            r_duty       <= DUTY_MIN_RST;
            r_step_timer <= '0;
            r_hold_timer <= '0;
        end else if (i_en) begin
            r_phase      <= n_phase;
            r_duty       <= n_duty;
            r_step_timer <= n_step_timer;
            r_hold_timer <= n_hold_timer;
        end
    end

    assign o_next.duty  = n_duty;
    assign o_next.phase = n_phase;

    // The ramp never jumps from accelerate straight into the mirrored hold.
    a_no_accel_to_mirror: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_phase == PH_ACCEL) |=> (r_phase != PH_MIRROR))
        else $error("accelerate went straight to mirrored hold");

    // The measured hold is never re-entered from the mirrored hold.
    a_no_mirror_to_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_phase == PH_MIRROR) |=> (r_phase != PH_HOLD))
        else $error("mirrored hold went back to hold");

    // Ramp state moves only on a tick.
    a_state_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> ($stable(r_duty) && $stable(r_phase) && $stable(r_hold_timer)))
        else $error("ramp state changed without a tick");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the trapezoidal duty ramp unit with a tick-level ramp predictor.
module tb_top;
    import tdr_pkg::*;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned PIPE_LAT    = 2;
    localparam int unsigned PHASE_TICKS = 155;

    // Spare register indexes that the block has to ignore.
    localparam logic [CIDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CIDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct {
        logic [PULSE_W-1:0] now;
        logic [PULSE_W-1:0] target;
    } t_tick_in;

    typedef struct {
        logic [CIDX_W-1:0]  index;
        logic [CDATA_W-1:0] data;
    } t_reg_write;

    logic i_clk;
    logic i_rst_n;

    tdr_in_if  in_ch ();
    tdr_cfg_if cfg_ch ();
    tdr_out_if out_ch ();

    trapezoidal_duty_ramp_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    // Pending stimulus and expected results.
    t_tick_in   tick_in_q[$];
    t_reg_write reg_write_q[$];
    t_result    tick_exp_q[$];

    // Shadow copy of the ramp state and its register set.
    t_phase            sh_phase;
    logic [DUTY_W-1:0] sh_duty;
    logic [IVL_W-1:0]  sh_step_tmr;
    logic [HOLD_W-1:0] sh_hold_tmr;
    t_cfg              sh_cfg;

    bit in_acc;
    bit cfg_acc;
    bit idle_en;
    int in_gap;
    int rdy_gap;
    int stall_cnt;
    int mismatch_cnt;
    int ticks_checked;
    int reg_writes;
    int phase_seen[4];

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        mismatch_cnt++;
        if (mismatch_cnt <= 50) $display("mismatch at %0t: %s", $time, what);
    endtask

    // Advance the shadow ramp by one millisecond tick and return duty and phase after it.
    task automatic ramp_advance(input logic [PULSE_W-1:0] now, input logic [PULSE_W-1:0] target,
                                output t_result res);
        logic              below;
        logic [DUTY_W:0]   sum;
        below = now < (target >> 1);
        if (sh_step_tmr != '0) sh_step_tmr = sh_step_tmr - 1'b1;
        if (below) begin
            case (sh_phase)
                PH_ACCEL: begin
                    if (sh_duty < sh_cfg.duty_max) begin
                        if (sh_step_tmr == '0) begin
                            sum = {1'b0, sh_duty} + {1'b0, sh_cfg.step_up};
                            sh_step_tmr = sh_cfg.step_ivl;
                            sh_duty = (sum > {1'b0, sh_cfg.duty_max}) ? sh_cfg.duty_max
                                                                      : sum[DUTY_W-1:0];
                        end
                    end else begin
                        sh_phase = PH_HOLD;
                        sh_hold_tmr = '0;
                    end
                end
                PH_HOLD: begin
                    if (sh_hold_tmr < sh_cfg.hold_limit) sh_hold_tmr = sh_hold_tmr + 1'b1;
                end
                default: sh_phase = PH_ACCEL;
            endcase
        end else begin
            case (sh_phase)
                PH_HOLD: sh_phase = PH_MIRROR;
                PH_MIRROR: begin
                    if (sh_hold_tmr == '0) sh_phase = PH_DECEL;
                    else sh_hold_tmr = sh_hold_tmr - 1'b1;
                end
                PH_DECEL: begin
                    if (sh_duty > sh_cfg.duty_min && sh_step_tmr == '0) begin
                        sh_step_tmr = sh_cfg.step_ivl;
                        if (sh_duty - sh_cfg.duty_min <= sh_cfg.step_down)
                            sh_duty = sh_cfg.duty_min;
                        else
                            sh_duty = sh_duty - sh_cfg.step_down;
                    end
                end
                default: sh_phase = PH_DECEL;
            endcase
        end
        res.duty = sh_duty;
        res.phase = sh_phase;
    endtask

    // Monitor: sample beats at the rising edge, predict accepted ticks, check results.
    always @(posedge i_clk) begin : ramp_monitor
        t_result want;
        t_result fresh;
        if (!i_rst_n) begin
            in_acc      <= 1'b0;
            cfg_acc     <= 1'b0;
            sh_phase    = PH_ACCEL;
            sh_duty     = DUTY_MIN_RST;
            sh_step_tmr = '0;
            sh_hold_tmr = '0;
            sh_cfg      = '{duty_min: DUTY_MIN_RST, duty_max: DUTY_MAX_RST,
                            step_up: STEP_UP_RST, step_down: STEP_DOWN_RST,
                            step_ivl: STEP_IVL_RST, hold_limit: HOLD_LIMIT_RST};
        end else begin
            in_acc  <= in_ch.valid && in_ch.ready;
            cfg_acc <= cfg_ch.valid && cfg_ch.ready;
            if (out_ch.valid && out_ch.ready) begin
                if (tick_exp_q.size() == 0) begin
                    report_mismatch($sformatf("result beat duty=%0d phase=%0d with no tick pending",
                                              out_ch.duty, out_ch.phase));
                end else begin
                    want = tick_exp_q.pop_front();
                    ticks_checked++;
                    phase_seen[want.phase]++;
                    if (out_ch.duty !== want.duty)
                        report_mismatch($sformatf("tick %0d: duty %0d, expected %0d",
                                                  ticks_checked, out_ch.duty, want.duty));
                    if (out_ch.phase !== want.phase)
                        report_mismatch($sformatf("tick %0d: phase %0d, expected %0d",
                                                  ticks_checked, out_ch.phase, want.phase));
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                reg_writes++;
                case (cfg_ch.index)
                    REG_DUTY_MIN:   sh_cfg.duty_min   = cfg_ch.data[DUTY_W-1:0];
                    REG_DUTY_MAX:   sh_cfg.duty_max   = cfg_ch.data[DUTY_W-1:0];
                    REG_STEP_UP:    sh_cfg.step_up    = cfg_ch.data[STEP_W-1:0];
                    REG_STEP_DOWN:  sh_cfg.step_down  = cfg_ch.data[STEP_W-1:0];
                    REG_STEP_IVL:   sh_cfg.step_ivl   = cfg_ch.data[IVL_W-1:0];
                    REG_HOLD_LIMIT: sh_cfg.hold_limit = cfg_ch.data[HOLD_W-1:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                ramp_advance(in_ch.pulses_now, in_ch.pulses_target, fresh);
                tick_exp_q.push_back(fresh);
            end
        end
    end

    // Driver: all block inputs change at the falling edge.
    always @(negedge i_clk) begin : beat_driver
        t_tick_in   tick;
        t_reg_write wr;
        if (!i_rst_n) begin
            in_ch.valid  <= 1'b0;
            cfg_ch.valid <= 1'b0;
            out_ch.ready <= 1'b0;
        end else begin
            // Result side back-pressure in bursts.
            if (rdy_gap != 0) begin
                rdy_gap--;
                out_ch.ready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 9) == 0) begin
                rdy_gap = $urandom_range(0, 15);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end

            // Tick beats, with idle bursts between them.
            if (!in_ch.valid || in_acc) begin
                if (in_gap != 0) begin
                    in_gap--;
                    in_ch.valid <= 1'b0;
                end else if (idle_en && tick_in_q.size() != 0 && $urandom_range(0, 9) == 0) begin
                    in_gap = $urandom_range(0, 15);
                    in_ch.valid <= 1'b0;
                end else if (tick_in_q.size() != 0) begin
                    tick = tick_in_q.pop_front();
                    in_ch.valid         <= 1'b1;
                    in_ch.pulses_now    <= tick.now;
                    in_ch.pulses_target <= tick.target;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end

            // Register writes.
            if (!cfg_ch.valid || cfg_acc) begin
                if (reg_write_q.size() != 0) begin
                    wr = reg_write_q.pop_front();
                    cfg_ch.valid <= 1'b1;
                    cfg_ch.index <= wr.index;
                    cfg_ch.data  <= wr.data;
                end else begin
                    cfg_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
            $display("tb: failure");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    task automatic push_tick(input logic [PULSE_W-1:0] now, input logic [PULSE_W-1:0] target);
        tick_in_q.push_back('{now: now, target: target});
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] index, input int unsigned value);
        reg_write_q.push_back('{index: index, data: value[CDATA_W-1:0]});
    endtask

    task automatic write_settings(input int unsigned dmin, input int unsigned dmax,
                                  input int unsigned up, input int unsigned down,
                                  input int unsigned ivl, input int unsigned hold);
        write_reg(REG_DUTY_MIN, dmin);
        write_reg(REG_DUTY_MAX, dmax);
        write_reg(REG_STEP_UP, up);
        write_reg(REG_STEP_DOWN, down);
        write_reg(REG_STEP_IVL, ivl);
        write_reg(REG_HOLD_LIMIT, hold);
    endtask

    // Wait until every queued beat is taken and every result has come back, then let the
    // pipeline settle. Returns at a rising edge so new pushes never race the driver.
    task automatic settle();
        @(negedge i_clk);
        while (tick_in_q.size() != 0 || in_ch.valid || reg_write_q.size() != 0 ||
               cfg_ch.valid || tick_exp_q.size() != 0)
            @(negedge i_clk);
        repeat (PIPE_LAT + 2) @(posedge i_clk);
    endtask

    function automatic int unsigned edge_pick(input int unsigned lo, input int unsigned hi);
        case ($urandom_range(0, 4))
            0:       return lo;
            1:       return hi;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    // One move: ticks below the halfway point, then ticks from halfway toward the target.
    task automatic push_move();
        logic [PULSE_W-1:0] target;
        logic [PULSE_W-1:0] half;
        int                 n_lo;
        int                 n_hi;
        longint             span;
        target = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(200000, 2);
        half = target >> 1;
        n_lo = (half == 0) ? 0 : $urandom_range(40, 0);
        n_hi = $urandom_range(60, 1);
        for (int i = 0; i < n_lo; i++)
            push_tick(32'((longint'(half) * i) / n_lo), target);
        span = longint'(target) - longint'(half);
        for (int i = 0; i < n_hi; i++)
            push_tick(32'(longint'(half) + (span * i) / n_hi), target);
    endtask

    // Stimulus sequence.
    initial begin
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.pulses_now    = '0;
        in_ch.pulses_target = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;
        out_ch.ready        = 1'b0;
        idle_en             = 1'b1;
        in_gap              = 0;
        rdy_gap             = 0;
        stall_cnt           = 0;
        mismatch_cnt        = 0;
        ticks_checked       = 0;
        reg_writes          = 0;
        for (int i = 0; i < 4; i++) phase_seen[i] = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: field extremes and the halfway boundary, no duty step taken.
        push_tick(32'd0, 32'd0);
        push_tick(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_tick(32'd0, 32'd1);
        push_tick(32'hFFFF_FFFF, 32'd0);
        push_tick(32'd0, 32'd2);
        push_tick(32'h7FFF_FFFF, 32'hFFFF_FFFF);
        settle();

        // Full-scale steps with a zero interval; spare indexes must be ignored.
        write_settings(0, 100, 100, 100, 0, 65535);
        write_reg(REG_SPARE_LO, 16'hFFFF);
        write_reg(REG_SPARE_HI, 16'hFFFF);
        settle();
        for (int i = 0; i < 6; i++) push_tick(i, 32'd100);
        settle();
        // Lower the hold limit below the measured hold, then run the mirrored hold.
        write_reg(REG_HOLD_LIMIT, 1);
        settle();
        push_tick(32'd6, 32'd100);
        for (int i = 5; i <= 10; i++) push_tick(i * 10, 32'd100);
        push_tick(32'hFFFF_FFFF, 32'd100);
        settle();

        // Floor above ceiling and zero steps.
        write_settings(80, 20, 0, 0, 2, 65535);
        settle();
        push_tick(32'd0, 32'd10);
        push_tick(32'd1, 32'd10);
        push_tick(32'd2, 32'd10);
        push_tick(32'd9, 32'd10);
        settle();

        // Random moves under changing settings; no idling in the last two phases.
        for (int p = 0; p < 8; p++) begin
            if (p == 6) idle_en = 1'b0;
            case (p)
                0: write_settings(0, 100, 1, 1, 1, 1);
                1: write_settings(100, 100, 100, 100, 1000, 65535);
                default: begin
                    if ($urandom_range(0, 3) != 0)
                        write_settings($urandom_range(50, 0), $urandom_range(100, 50),
                                       edge_pick(1, 100), edge_pick(1, 100),
                                       ($urandom_range(0, 3) != 0) ? $urandom_range(4, 0)
                                                                   : edge_pick(1, 1000),
                                       ($urandom_range(0, 1) != 0) ? $urandom_range(40, 1)
                                                                   : edge_pick(1, 65535));
                    else
                        write_settings(edge_pick(0, 100), edge_pick(0, 100),
                                       edge_pick(1, 100), edge_pick(1, 100),
                                       edge_pick(1, 1000), edge_pick(1, 65535));
                end
            endcase
            settle();
            while (tick_in_q.size() < PHASE_TICKS) begin
                if ($urandom_range(0, 7) == 0) push_tick($urandom, $urandom);
                else push_move();
            end
            settle();
        end

        repeat (PIPE_LAT + 4) @(posedge i_clk);
        $display("summary: %0d ticks checked, %0d register writes, %0d mismatches",
                 ticks_checked, reg_writes, mismatch_cnt);
        $display("summary: ticks per phase accel %0d, hold %0d, mirror %0d, decel %0d",
                 phase_seen[PH_ACCEL], phase_seen[PH_HOLD], phase_seen[PH_MIRROR],
                 phase_seen[PH_DECEL]);
        if (mismatch_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[trapezoidal_duty_ramp_unit.f]
src/tdr_pkg.sv
src/tdr_if.sv
src/tdr_ramp_core.sv
src/trapezoidal_duty_ramp_unit.sv
tb/tb_top.sv
